// File: rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked on clk_i, disabled in reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Antecedent implies consequent in the same cycle.
`define ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("assertion failed");

// Antecedent implies consequent in the following cycle.
`define ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("assertion failed");

// Condition holds at every clock edge.
`define ASSERT_ALWAYS(label, cond) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond)) \
    else $error("assertion failed");

`endif

// File: rtl/kvs_pkg.sv
// ----------------------------------------------------------------------------
// kvs_pkg
// Widths, codes and shared types of the keyframe visibility sampler.
// ----------------------------------------------------------------------------
package kvs_pkg;

  localparam int unsigned TimeW = 32;
  localparam int unsigned ValW  = 24;
  localparam int unsigned VisW  = 17;
  localparam int unsigned QuoW  = 24;
  localparam int unsigned ProdW = 57;
  localparam int unsigned NumW  = 58;

  localparam logic [VisW-1:0] VisOne = 17'h10000;

  typedef enum logic [1:0] {
    KindClear  = 2'd0,
    KindAppend = 2'd1,
    KindSample = 2'd2
  } kvs_kind_e;

  typedef struct packed {
    logic busy;
    logic done;
  } kvs_div_stat_t;

endpackage

// File: rtl/kvs_div.sv
// ----------------------------------------------------------------------------
// kvs_div
// Signed by unsigned restoring divider, one quotient bit per cycle,
// truncating toward zero. The quotient magnitude is below 2^QuoW.
// ----------------------------------------------------------------------------
module kvs_div (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start_i,
  input  logic signed [kvs_pkg::NumW-1:0]   num_i,
  input  logic        [kvs_pkg::TimeW-1:0]  den_i,
  output kvs_pkg::kvs_div_stat_t            stat_o,
  output logic        [kvs_pkg::QuoW-1:0]   quot_o,
  output logic                              neg_o
);
  import kvs_pkg::*;

  localparam int unsigned CntW = $clog2(QuoW + 1);

  logic              busy_q, busy_d;
  logic              done_q, done_d;
  logic              neg_q, neg_d;
  logic [CntW-1:0]   cnt_q, cnt_d;
  logic [TimeW-1:0]  rem_q, rem_d;
  logic [QuoW-1:0]   quo_q, quo_d;
  logic [NumW-1:0]   mag;
  logic [TimeW:0]    trial;
  logic [TimeW:0]    diff;
  logic              ge;

  assign mag   = num_i[NumW-1] ? NumW'(-num_i) : NumW'(num_i);
  assign trial = {rem_q, quo_q[QuoW-1]};
  assign ge    = trial >= {1'b0, den_i};
  assign diff  = trial - {1'b0, den_i};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    neg_d  = neg_q;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    quo_d  = quo_q;
    if (start_i) begin
      neg_d  = num_i[NumW-1];
      rem_d  = mag[TimeW+QuoW-1:QuoW];
      quo_d  = mag[QuoW-1:0];
      cnt_d  = CntW'(QuoW);
      busy_d = 1'b1;
    end else if (busy_q) begin
      rem_d = ge ? diff[TimeW-1:0] : trial[TimeW-1:0];
      quo_d = {quo_q[QuoW-2:0], ge};
      cnt_d = cnt_q - CntW'(1);
      if (cnt_q == CntW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      neg_q  <= 1'b0;
      cnt_q  <= '0;
      rem_q  <= '0;
      quo_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      neg_q  <= neg_d;
      cnt_q  <= cnt_d;
      rem_q  <= rem_d;
      quo_q  <= quo_d;
    end
  end

  assign stat_o.busy = busy_q;
  assign stat_o.done = done_q;
  assign quot_o      = quo_q;
  assign neg_o       = neg_q;

endmodule

// File: rtl/keyframe_visibility_sampler_unit.sv
// ----------------------------------------------------------------------------
// keyframe_visibility_sampler_unit
// Keyframe table with cursor walk and linear interpolation of visibility.
// ----------------------------------------------------------------------------
// Channel  Direction  Handshake                Payload
// in       input      in_valid_i / in_stall_o  kind_i, time_point_i, key_value_i
// out      output     out_valid_o / out_stall_i visibility_o, no_keys_o
//
// Clear and append finish in ST_IDLE. A sample on an empty table goes to ST_EMIT.
// Other samples walk the keys through the single table read port, ST_RD then
// ST_CMP per key; a cursor rewind restarts at key 0. A time between two keys
// adds ST_RDC, ST_LOADC, ST_MUL1, ST_MUL2, ST_SUM, ST_DIVGO, the divider, ST_EMIT.
// Reset clears key count, cursor and handshake state; table contents stay.
// Input is stalled from a sample's acceptance until its result reaches the output register.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module keyframe_visibility_sampler_unit #(
  parameter int unsigned MAX_KEYS = 64
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic        [1:0]                 kind_i,
  input  logic        [kvs_pkg::TimeW-1:0]  time_point_i,
  input  logic signed [kvs_pkg::ValW-1:0]   key_value_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic        [kvs_pkg::VisW-1:0]   visibility_o,
  output logic                              no_keys_o
);
  import kvs_pkg::*;

  localparam int unsigned IdxW = $clog2(MAX_KEYS);
  localparam int unsigned CntW = $clog2(MAX_KEYS + 1);

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_RD,
    ST_CMP,
    ST_RDC,
    ST_LOADC,
    ST_MUL1,
    ST_MUL2,
    ST_SUM,
    ST_DIVGO,
    ST_DIVW,
    ST_EMIT
  } state_e;

  state_e                    state_q, state_d;
  logic        [IdxW-1:0]    cursor_q, cursor_d;
  logic        [CntW-1:0]    count_q, count_d;
  logic                      first_q, first_d;
  logic        [TimeW-1:0]   time_q, time_d;
  logic        [TimeW-1:0]   tx_q, tx_d;
  logic signed [ValW-1:0]    vx_q, vx_d;
  logic        [TimeW-1:0]   da_q, da_d;
  logic        [TimeW-1:0]   db_q, db_d;
  logic        [TimeW-1:0]   den_q, den_d;
  logic signed [ProdW-1:0]   acc_q, acc_d;
  logic signed [ProdW-1:0]   prod_q, prod_d;
  logic signed [NumW-1:0]    num_q, num_d;
  logic        [VisW-1:0]    res_q, res_d;
  logic                      nk_q, nk_d;
  logic                      out_valid_q, out_valid_d;
  logic        [VisW-1:0]    vis_q, vis_d;
  logic                      out_nk_q, out_nk_d;

  logic        [TimeW-1:0]   key_time_mem [MAX_KEYS];
  logic signed [ValW-1:0]    key_val_mem  [MAX_KEYS];
  logic        [TimeW-1:0]   rd_time_q;
  logic signed [ValW-1:0]    rd_val_q;

  logic                      in_xfer;
  logic                      full;
  logic                      last;
  logic                      wr_en;
  logic                      rd_en;
  logic signed [TimeW:0]     mul_a;
  logic signed [ValW-1:0]    mul_b;
  logic signed [ProdW-1:0]   mul_p;

  kvs_div_stat_t             div_stat;
  logic        [QuoW-1:0]    div_quot;
  logic                      div_neg;

  function automatic logic [VisW-1:0] clamp_val(input logic signed [ValW-1:0] v);
    logic [VisW-1:0] r;
    if (v[ValW-1]) begin
      r = '0;
    end else if ($unsigned(v) > ValW'(VisOne)) begin
      r = VisOne;
    end else begin
      r = v[VisW-1:0];
    end
    return r;
  endfunction

  assign in_stall_o = (state_q != ST_IDLE);
  assign in_xfer    = in_valid_i && !in_stall_o;
  assign full       = (count_q == CntW'(MAX_KEYS));
  assign last       = (CntW'(cursor_q) + CntW'(1) == count_q);
  assign wr_en      = in_xfer && (kind_i == KindAppend) && !full;
  assign rd_en      = (state_q == ST_RD) || (state_q == ST_RDC);

  assign mul_a = (state_q == ST_MUL1) ? $signed({1'b0, da_q}) : $signed({1'b0, db_q});
  assign mul_b = (state_q == ST_MUL1) ? vx_q : rd_val_q;
  assign mul_p = mul_a * mul_b;

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      key_time_mem[count_q[IdxW-1:0]] <= time_point_i;
      key_val_mem[count_q[IdxW-1:0]]  <= key_value_i;
    end
    if (rd_en) begin
      rd_time_q <= key_time_mem[cursor_q];
      rd_val_q  <= key_val_mem[cursor_q];
    end
  end

  kvs_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (state_q == ST_DIVGO),
    .num_i   (num_q),
    .den_i   (den_q),
    .stat_o  (div_stat),
    .quot_o  (div_quot),
    .neg_o   (div_neg)
  );

  always_comb begin
    state_d     = state_q;
    cursor_d    = cursor_q;
    count_d     = count_q;
    first_d     = first_q;
    time_d      = time_q;
    tx_d        = tx_q;
    vx_d        = vx_q;
    da_d        = da_q;
    db_d        = db_q;
    den_d       = den_q;
    acc_d       = acc_q;
    prod_d      = prod_q;
    num_d       = num_q;
    res_d       = res_q;
    nk_d        = nk_q;
    out_valid_d = out_valid_q;
    vis_d       = vis_q;
    out_nk_d    = out_nk_q;

    if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          unique case (kind_i)
            KindClear: begin
              count_d  = '0;
              cursor_d = '0;
            end
            KindAppend: begin
              if (!full) begin
                count_d = count_q + CntW'(1);
              end
            end
            KindSample: begin
              time_d = time_point_i;
              if (count_q == '0) begin
                res_d   = VisOne;
                nk_d    = 1'b1;
                state_d = ST_EMIT;
              end else begin
                nk_d    = 1'b0;
                first_d = 1'b1;
                state_d = ST_RD;
              end
            end
            default: ;
          endcase
        end
      end
      ST_RD: begin
        state_d = ST_CMP;
      end
      ST_CMP: begin
        first_d = 1'b0;
        if (first_q && (time_q < rd_time_q) && (cursor_q != '0)) begin
          cursor_d = '0;
          state_d  = ST_RD;
        end else if (rd_time_q <= time_q) begin
          if (last) begin
            res_d   = clamp_val(rd_val_q);
            state_d = ST_EMIT;
          end else begin
            cursor_d = cursor_q + IdxW'(1);
            state_d  = ST_RD;
          end
        end else if (cursor_q == '0) begin
          res_d   = clamp_val(rd_val_q);
          state_d = ST_EMIT;
        end else begin
          tx_d     = rd_time_q;
          vx_d     = rd_val_q;
          cursor_d = cursor_q - IdxW'(1);
          state_d  = ST_RDC;
        end
      end
      ST_RDC: begin
        state_d = ST_LOADC;
      end
      ST_LOADC: begin
        da_d    = time_q - rd_time_q;
        db_d    = tx_q - time_q;
        den_d   = tx_q - rd_time_q;
        state_d = ST_MUL1;
      end
      ST_MUL1: begin
        acc_d   = mul_p;
        state_d = ST_MUL2;
      end
      ST_MUL2: begin
        prod_d  = mul_p;
        state_d = ST_SUM;
      end
      ST_SUM: begin
        num_d   = {acc_q[ProdW-1], acc_q} + {prod_q[ProdW-1], prod_q};
        state_d = ST_DIVGO;
      end
      ST_DIVGO: begin
        state_d = ST_DIVW;
      end
      ST_DIVW: begin
        if (div_stat.done) begin
          if (div_neg) begin
            res_d = '0;
          end else if (div_quot > QuoW'(VisOne)) begin
            res_d = VisOne;
          end else begin
            res_d = div_quot[VisW-1:0];
          end
          state_d = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (!out_valid_q || !out_stall_i) begin
          out_valid_d = 1'b1;
          vis_d       = res_q;
          out_nk_d    = nk_q;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cursor_q    <= '0;
      count_q     <= '0;
      first_q     <= 1'b0;
      time_q      <= '0;
      tx_q        <= '0;
      vx_q        <= '0;
      da_q        <= '0;
      db_q        <= '0;
      den_q       <= '0;
      acc_q       <= '0;
      prod_q      <= '0;
      num_q       <= '0;
      res_q       <= '0;
      nk_q        <= 1'b0;
      out_valid_q <= 1'b0;
      vis_q       <= '0;
      out_nk_q    <= 1'b0;
    end else begin
      state_q     <= state_d;
      cursor_q    <= cursor_d;
      count_q     <= count_d;
      first_q     <= first_d;
      time_q      <= time_d;
      tx_q        <= tx_d;
      vx_q        <= vx_d;
      da_q        <= da_d;
      db_q        <= db_d;
      den_q       <= den_d;
      acc_q       <= acc_d;
      prod_q      <= prod_d;
      num_q       <= num_d;
      res_q       <= res_d;
      nk_q        <= nk_d;
      out_valid_q <= out_valid_d;
      vis_q       <= vis_d;
      out_nk_q    <= out_nk_d;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign visibility_o = vis_q;
  assign no_keys_o    = out_nk_q;

  `ASSERT_ALWAYS(a_count_bound, count_q <= CntW'(MAX_KEYS))
  `ASSERT_IMPL(a_cursor_in_table, count_q != '0, CntW'(cursor_q) < count_q)
  `ASSERT_IMPL(a_div_done_waited, div_stat.done, state_q == ST_DIVW)
  `ASSERT_IMPL(a_div_busy_waited, div_stat.busy, state_q == ST_DIVW)
  `ASSERT_IMPL(a_rise_from_emit, $rose(out_valid_q), $past(state_q) == ST_EMIT)
  `ASSERT_IMPL(a_vis_range, out_valid_q, vis_q <= VisOne)

endmodule

// File: tb/sv/tb_keyframe_visibility_sampler_unit.sv
// ----------------------------------------------------------------------------
// tb_keyframe_visibility_sampler_unit
// Self-checking bench for the keyframe visibility sampler. Drives clear,
// append and sample transfers, with directed corner cases first and then
// random key tracks. A scoreboard mirrors the table and cursor, predicts each
// sample result and checks it against the output channel. The input idles
// and the output stalls at random.
// ----------------------------------------------------------------------------
module tb_keyframe_visibility_sampler_unit;
  timeunit 1ns;
  timeprecision 1ps;

  import kvs_pkg::*;

  localparam int unsigned MaxKeys    = 64;
  localparam int          ItemTarget = 1150;
  localparam int          IdleLimit  = 4000;
  localparam int          TailCycles = 400;

  localparam logic [1:0] KindUnused = 2'd3;

  typedef struct {
    logic [VisW-1:0] vis;
    logic            no_keys;
  } vis_result_t;

  class vis_scoreboard;
    logic        [TimeW-1:0] key_tm  [MaxKeys];
    logic signed [ValW-1:0]  key_val [MaxKeys];
    int unsigned             n_keys;
    int unsigned             cur;
    vis_result_t             vis_q[$];
    int                      errors;

    function new();
      n_keys = 0;
      cur    = 0;
      errors = 0;
    endfunction

    function logic [VisW-1:0] clamp(longint v);
      if (v < 0) return '0;
      if (v > longint'(VisOne)) return VisOne;
      return v[VisW-1:0];
    endfunction

    function int pending();
      return vis_q.size();
    endfunction

    function void note_item(logic [1:0] kind, logic [TimeW-1:0] tp, logic [ValW-1:0] kv);
      vis_result_t r;
      int unsigned c, x;
      longint      tt, tc, tx, vc, vx, num, den;
      case (kind)
        KindClear: begin
          n_keys = 0;
          cur    = 0;
        end
        KindAppend: begin
          if (n_keys < MaxKeys) begin
            key_tm[n_keys]  = tp;
            key_val[n_keys] = kv;
            n_keys++;
          end
        end
        KindSample: begin
          r.no_keys = 1'b0;
          if (n_keys == 0) begin
            r.vis     = VisOne;
            r.no_keys = 1'b1;
          end else begin
            if (cur >= n_keys) cur = 0;
            if (tp < key_tm[cur]) cur = 0;
            while (cur < n_keys && key_tm[cur] <= tp) cur++;
            if (cur >= n_keys) begin
              cur   = n_keys - 1;
              r.vis = clamp(key_val[cur]);
            end else if (cur == 0) begin
              r.vis = clamp(key_val[0]);
            end else begin
              x   = cur;
              c   = cur - 1;
              cur = c;
              tt  = tp;
              tc  = key_tm[c];
              tx  = key_tm[x];
              vc  = key_val[c];
              vx  = key_val[x];
              den = tx - tc;
              if (den <= 0) begin
                r.vis = clamp(vc);
              end else begin
                num   = (tt - tc) * vx + (tx - tt) * vc;
                r.vis = clamp(num / den);
              end
            end
          end
          vis_q = {vis_q, r};
        end
        default: ;
      endcase
    endfunction

    function void check_result(logic [VisW-1:0] vis, logic no_keys);
      vis_result_t e;
      if (vis_q.size() == 0) begin
        $display("%0t: unexpected result visibility=%0d no_keys=%0d", $time, vis, no_keys);
        errors++;
        return;
      end
      e = vis_q.pop_front();
      if (vis !== e.vis) begin
        $display("%0t: visibility mismatch expected=%0d actual=%0d", $time, e.vis, vis);
        errors++;
      end
      if (no_keys !== e.no_keys) begin
        $display("%0t: no_keys mismatch expected=%0d actual=%0d", $time, e.no_keys, no_keys);
        errors++;
      end
    endfunction
  endclass

  logic                   clk_i        = 1'b0;
  logic                   rst_ni       = 1'b0;
  logic                   in_valid_i   = 1'b0;
  logic                   in_stall_o;
  logic [1:0]             kind_i       = KindClear;
  logic [TimeW-1:0]       time_point_i = '0;
  logic signed [ValW-1:0] key_value_i  = '0;
  logic                   out_valid_o;
  logic                   out_stall_i  = 1'b0;
  logic [VisW-1:0]        visibility_o;
  logic                   no_keys_o;

  vis_scoreboard    sb;
  logic [TimeW-1:0] track_tm[$];
  bit               idle_en     = 1'b1;
  int               items_sent  = 0;
  int               idle_cycles = 0;
  int               stall_left  = 0;

  keyframe_visibility_sampler_unit #(
    .MAX_KEYS(MaxKeys)
  ) DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .kind_i      (kind_i),
    .time_point_i(time_point_i),
    .key_value_i (key_value_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .visibility_o(visibility_o),
    .no_keys_o   (no_keys_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(99, 0);
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(3, 1);
    if (r < 97) return $urandom_range(15, 4);
    return $urandom_range(80, 30);
  endfunction

  function automatic logic [ValW-1:0] pick_key_value();
    int r;
    r = $urandom_range(19, 0);
    if (r < 14) return ValW'($urandom_range(65536, 0));
    if (r < 17) return ValW'(int'($urandom_range(210000, 0)) - 70000);
    return ValW'($urandom());
  endfunction

  function automatic logic [TimeW-1:0] pick_sample_time();
    int          r;
    int unsigned i, j;
    r = $urandom_range(9, 0);
    if (track_tm.size() == 0 || r == 9) return $urandom();
    i = $urandom_range(track_tm.size() - 1, 0);
    j = $urandom_range(track_tm.size() - 1, 0);
    case (r)
      0:       return '0;
      1:       return '1;
      2, 3, 4: return track_tm[i];
      5:       return track_tm[i] + 1;
      6:       return track_tm[i] - 1;
      default: return $urandom_range(track_tm[i], track_tm[j]);
    endcase
  endfunction

  // Hold the payload until the transfer completes.
  task automatic send(input logic [1:0] kind, input logic [TimeW-1:0] tp,
                      input logic [ValW-1:0] kv);
    int gap;
    gap = idle_en ? pick_gap() : 0;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i   <= 1'b1;
    kind_i       <= kind;
    time_point_i <= tp;
    key_value_i  <= kv;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    sb.note_item(kind, tp, kv);
    if (kind != KindUnused) items_sent++;
  endtask

  // Drop valid, then hold until every expected result has come.
  task automatic wait_drained();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (sb.pending() != 0) @(posedge clk_i);
  endtask

  task automatic append_keys(input int n);
    logic [TimeW-1:0] t;
    int               r;
    r = $urandom_range(9, 0);
    if (track_tm.size() != 0) t = track_tm[track_tm.size() - 1];
    else if (r < 3) t = '0;
    else if (r < 8) t = $urandom_range(32'h0010_0000, 0);
    else t = $urandom();
    repeat (n) begin
      r = $urandom_range(11, 0);
      if (r == 0) t = $urandom();
      else if (r < 3) t = t + $urandom_range(16, 0);
      else t = t + $urandom_range(1 << $urandom_range(24, 4), 1);
      send(KindAppend, t, pick_key_value());
      track_tm = {track_tm, t};
    end
  endtask

  task automatic run_track(input int n_keys);
    idle_en = ($urandom_range(4, 0) != 0);
    send(KindClear, $urandom(), ValW'($urandom()));
    track_tm.delete();
    if ($urandom_range(19, 0) == 0) send(KindSample, $urandom(), ValW'($urandom()));
    append_keys(n_keys);
    repeat ($urandom_range(10, 2)) send(KindSample, pick_sample_time(), ValW'($urandom()));
    if ($urandom_range(3, 0) == 0) begin
      append_keys($urandom_range(4, 1));
      repeat ($urandom_range(6, 1)) send(KindSample, pick_sample_time(), ValW'($urandom()));
    end
  endtask

  // Stall the output channel at random.
  always @(posedge clk_i) begin
    if (stall_left == 0 && idle_en && $urandom_range(3, 0) == 0) stall_left = pick_gap();
    if (stall_left > 0) begin
      out_stall_i <= 1'b1;
      stall_left--;
    end else begin
      out_stall_i <= 1'b0;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) sb.check_result(visibility_o, no_keys_o);
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= IdleLimit) begin
        $display("%0t: no transfer for %0d cycles", $time, IdleLimit);
        $display("TEST FAILED");
        $finish;
      end
    end
  end

  initial begin
    int r;
    sb = new();
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send(KindSample, 32'hFFFF_FFFF, 24'h00_0000);
    send(KindUnused, $urandom(), ValW'($urandom()));
    send(KindAppend, 32'h0001_0000, 24'h00_0000);
    send(KindSample, 32'h0000_0000, 24'h00_0000);
    send(KindSample, 32'h0001_0000, 24'h00_0000);
    send(KindAppend, 32'h0003_0000, 24'h01_0000);
    send(KindSample, 32'h0002_0000, 24'h00_0000);
    send(KindSample, 32'h0003_0000, 24'h00_0000);
    send(KindSample, 32'hFFFF_FFFF, 24'h00_0000);
    send(KindAppend, 32'h0004_0000, 24'h7F_FFFF);
    send(KindSample, 32'h0003_8000, 24'h00_0000);
    send(KindAppend, 32'h0005_0000, 24'h80_0000);
    send(KindSample, 32'h0004_8000, 24'h00_0000);
    send(KindSample, 32'h0001_0001, 24'hFF_FFFF);
    send(KindAppend, 32'h0002_0000, 24'h00_8000);
    send(KindSample, 32'h0002_8000, 24'h00_0000);
    send(KindSample, 32'h0004_FFFF, 24'h00_0000);
    send(KindClear, 32'hFFFF_FFFF, 24'hFF_FFFF);
    send(KindSample, 32'h0000_0000, 24'h00_0000);
    send(KindAppend, 32'hFFFF_FFFF, 24'h00_C000);
    send(KindSample, 32'hFFFF_FFFF, 24'h00_0000);
    send(KindSample, 32'h0000_0000, 24'h00_0000);
    send(KindClear, 32'h0000_0000, 24'h00_0000);
    send(KindAppend, 32'h0000_1000, 24'h00_4000);
    send(KindAppend, 32'h0000_1000, 24'h00_C000);
    send(KindSample, 32'h0000_1000, 24'h00_0000);
    wait_drained();

    // Fill the table past its capacity.
    run_track(MaxKeys + 2);

    while (items_sent < ItemTarget) begin
      r = $urandom_range(99, 0);
      if (r < 8) begin
        repeat ($urandom_range(4, 1))
          send(2'($urandom_range(3, 0)), $urandom(), ValW'($urandom()));
      end else if (r < 88) begin
        run_track($urandom_range(6, 1));
      end else if (r < 97) begin
        run_track($urandom_range(20, 7));
      end else begin
        run_track($urandom_range(MaxKeys + 6, MaxKeys - 4));
      end
      if ($urandom_range(29, 0) == 0) wait_drained();
    end

    wait_drained();
    repeat (TailCycles) @(posedge clk_i);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
